>>> rtl/rau_pkg.sv
// shared types and constants for the rational arithmetic unit
package rau_pkg;

  localparam int unsigned DefaultWidth = 32;
  localparam int unsigned OpW = 3;
  localparam int unsigned ResW = 64;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_MOD  = 3'd4,
    OP_QUO  = 3'd5,
    OP_RSV6 = 3'd6,
    OP_RSV7 = 3'd7
  } op_e;

  typedef struct packed {
    logic [OpW-1:0]     op;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } req_t;

  typedef struct packed {
    logic signed [ResW-1:0] res_num;
    logic signed [ResW-1:0] res_den;
    logic                   status;
  } rsp_t;

  // datapath commands
  typedef enum logic [3:0] {
    DC_LOAD  = 4'd0,
    DC_G1    = 4'd1,
    DC_FACT  = 4'd2,
    DC_SUM   = 4'd3,
    DC_G2    = 4'd4,
    DC_RED   = 4'd5,
    DC_INT   = 4'd6,
    DC_NONE  = 4'd7
  } dcmd_e;

  typedef struct packed {
    dcmd_e cmd;
    logic  go;
  } ctl_t;

  typedef struct packed {
    logic done;
    logic err;
    logic unused_op;
    logic int_op;
    logic fadd;
  } sts_t;

endpackage

>>> rtl/rau_div.sv
// restoring 64-bit unsigned divider, one quotient bit per cycle
module rau_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [rau_pkg::ResW-1:0] dvd_i,
  input  logic [rau_pkg::ResW-1:0] dvs_i,
  output logic                  done_o,
  output logic [rau_pkg::ResW-1:0] quo_o,
  output logic [rau_pkg::ResW-1:0] rem_o
);
  import rau_pkg::*;

  localparam int unsigned CntW = $clog2(ResW + 1);

  logic [ResW-1:0] quo_q, quo_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [ResW:0]   trial;
  logic [ResW:0]   diff;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[ResW-1]};
    diff   = trial - {1'b0, dvs_q};
    if (start_i) begin
      quo_d  = dvd_i;
      rem_d  = '0;
      dvs_d  = dvs_i;
      cnt_d  = CntW'(ResW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[ResW]) begin
        rem_d = diff[ResW-1:0];
        quo_d = {quo_q[ResW-2:0], 1'b1};
      end else begin
        rem_d = trial[ResW-1:0];
        quo_d = {quo_q[ResW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
endmodule

>>> rtl/rau_datapath.sv
// operand registers, multiplier and euclid sequencing around the divider
module rau_datapath #(
  parameter int unsigned Width = rau_pkg::DefaultWidth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rau_pkg::req_t req_i,
  input  rau_pkg::ctl_t ctl_i,
  output rau_pkg::sts_t sts_o,
  output rau_pkg::rsp_t rsp_o
);
  import rau_pkg::*;

  typedef logic [ResW-1:0] w_t;

  // division and multiply sub-steps within a command
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EUC  = 6'b000010,
    S_RN   = 6'b000100,
    S_RD   = 6'b001000,
    S_MUL  = 6'b010000,
    S_FIN  = 6'b100000
  } sub_e;

  function automatic w_t sx(input logic [31:0] v);
    logic [Width-1:0] t;
    t = v[Width-1:0];
    return w_t'(signed'(t));
  endfunction

  function automatic w_t mag(input w_t v);
    return v[ResW-1] ? w_t'(-v) : v;
  endfunction

  function automatic w_t sgn(input w_t m, input logic n);
    return n ? w_t'(-m) : m;
  endfunction

  sub_e sub_q, sub_d;
  op_e  op_q, op_d;
  w_t an_q, an_d, ad_q, ad_d, bn_q, bn_d, bd_q, bd_d;
  w_t x_q, x_d, y_q, y_d, num_q, num_d, den_q, den_d, fa_q, fa_d;
  logic [1:0] mstep_q, mstep_d;
  logic done_q, done_d;
  logic err_q, err_d, uop_q, uop_d;

  logic dv_start, dv_done;
  w_t   dv_a, dv_b, dv_quo, dv_rem;
  logic [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;

  rau_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dv_start),
    .dvd_i  (dv_a),
    .dvs_i  (dv_b),
    .done_o (dv_done),
    .quo_o  (dv_quo),
    .rem_o  (dv_rem)
  );

  assign mul_p = signed'(mul_a) * signed'(mul_b);

  always_comb begin
    sub_d = sub_q; op_d = op_q;
    an_d = an_q; ad_d = ad_q; bn_d = bn_q; bd_d = bd_q;
    x_d = x_q; y_d = y_q; num_d = num_q; den_d = den_q; fa_d = fa_q;
    mstep_d = mstep_q; done_d = 1'b0; err_d = err_q; uop_d = uop_q;
    dv_start = 1'b0; dv_a = x_q; dv_b = y_q;
    mul_a = '0; mul_b = '0;
    if (ctl_i.go) begin
      case (ctl_i.cmd)
        DC_LOAD: begin
          op_d = op_e'(req_i.op);
          an_d = sx(req_i.a_num); ad_d = sx(req_i.a_den);
          bn_d = sx(req_i.b_num); bd_d = sx(req_i.b_den);
          num_d = '0; den_d = w_t'(1);
          uop_d = (req_i.op > OP_QUO);
          err_d = !uop_d && ((sx(req_i.a_den) == '0)
                  || (req_i.op <= OP_DIV && sx(req_i.b_den) == '0)
                  || (req_i.op == OP_DIV && sx(req_i.b_num) == '0));
          done_d = 1'b1;
        end
        DC_G1: begin
          x_d = mag(ad_q); y_d = mag(bd_q); sub_d = S_EUC;
        end
        DC_G2: begin
          x_d = mag(num_q); y_d = mag(den_q); sub_d = S_EUC;
        end
        DC_FACT: begin
          sub_d = S_RN;
          dv_start = 1'b1; dv_a = mag(bd_q); dv_b = x_q;
        end
        DC_SUM: begin
          mstep_d = 2'd0; sub_d = S_MUL;
        end
        DC_RED: begin
          if (x_q == '0) begin
            done_d = 1'b1;
          end else begin
            sub_d = S_RN; dv_start = 1'b1; dv_a = mag(num_q); dv_b = x_q;
          end
        end
        DC_INT: begin
          sub_d = S_FIN; dv_start = 1'b1; dv_a = mag(an_q); dv_b = mag(ad_q);
        end
        default: ;
      endcase
    end
    case (sub_q)
      S_EUC: begin
        if (y_q == '0) begin
          sub_d = S_IDLE; done_d = 1'b1;
        end else begin
          if (!dv_done) begin
            dv_start = 1'b1; dv_a = x_q; dv_b = y_q; sub_d = S_RD;
          end
        end
      end
      S_RD: begin
        if (dv_done) begin
          if (op_q == OP_ADD || op_q == OP_SUB || op_q == OP_MUL
              || op_q == OP_DIV) begin
            x_d = y_q; y_d = dv_rem; sub_d = S_EUC;
          end
        end
      end
      S_RN: begin
        if (dv_done) begin
          if (ctl_i.cmd == DC_FACT) begin
            fa_d = sgn(dv_quo, bd_q[ResW-1]);
            sub_d = S_MUL; mstep_d = 2'd3;
            dv_start = 1'b1; dv_a = mag(ad_q); dv_b = x_q;
          end else begin
            num_d = sgn(dv_quo, num_q[ResW-1]);
            sub_d = S_FIN; dv_start = 1'b1; dv_a = mag(den_q); dv_b = x_q;
          end
        end
      end
      S_MUL: begin
        if (mstep_q == 2'd3) begin
          if (dv_done) begin
            y_d = sgn(dv_quo, ad_q[ResW-1]);
            sub_d = S_IDLE; done_d = 1'b1;
          end
        end else begin
          case (mstep_q)
            2'd0: begin
              if (op_q == OP_MUL) begin
                mul_a = an_q[31:0]; mul_b = bn_q[31:0];
              end else if (op_q == OP_DIV) begin
                mul_a = an_q[31:0]; mul_b = bd_q[31:0];
              end else begin
                mul_a = an_q[31:0]; mul_b = fa_q[31:0];
              end
              num_d = w_t'(mul_p);
            end
            2'd1: begin
              if (op_q == OP_MUL) begin
                mul_a = ad_q[31:0]; mul_b = bd_q[31:0]; den_d = w_t'(mul_p);
              end else if (op_q == OP_DIV) begin
                mul_a = ad_q[31:0]; mul_b = bn_q[31:0]; den_d = w_t'(mul_p);
              end else begin
                mul_a = bn_q[31:0]; mul_b = y_q[31:0];
                num_d = (op_q == OP_ADD) ? num_q + w_t'(mul_p)
                                         : num_q - w_t'(mul_p);
              end
            end
            default: begin
              mul_a = ad_q[31:0]; mul_b = fa_q[31:0];
              if (op_q == OP_ADD || op_q == OP_SUB) begin
                den_d = w_t'(mul_p);
              end
              sub_d = S_IDLE; done_d = 1'b1;
            end
          endcase
          mstep_d = mstep_q + 2'd1;
        end
      end
      S_FIN: begin
        if (dv_done) begin
          sub_d = S_IDLE; done_d = 1'b1;
          if (op_q == OP_MOD) begin
            num_d = sgn(dv_rem, an_q[ResW-1]); den_d = w_t'(1);
          end else if (op_q == OP_QUO) begin
            num_d = sgn(dv_quo, an_q[ResW-1] ^ ad_q[ResW-1]); den_d = w_t'(1);
          end else begin
            den_d = sgn(dv_quo, den_q[ResW-1]);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q   <= S_IDLE;
      mstep_q <= '0;
      done_q  <= 1'b0;
    end else begin
      sub_q   <= sub_d;
      mstep_q <= mstep_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; an_q <= an_d; ad_q <= ad_d; bn_q <= bn_d; bd_q <= bd_d;
    x_q <= x_d; y_q <= y_d; num_q <= num_d; den_q <= den_d; fa_q <= fa_d;
    err_q <= err_d; uop_q <= uop_d;
  end

  assign sts_o.done      = done_q;
  assign sts_o.err       = err_q;
  assign sts_o.unused_op = uop_q;
  assign sts_o.int_op    = (op_q == OP_MOD) || (op_q == OP_QUO);
  assign sts_o.fadd      = (op_q == OP_ADD) || (op_q == OP_SUB);
  assign rsp_o.res_num   = (err_q || uop_q) ? '0 : num_q;
  assign rsp_o.res_den   = (err_q || uop_q) ? w_t'(1) : den_q;
  assign rsp_o.status    = err_q;
endmodule

>>> rtl/rau_ctrl.sv
// controller sequencing the datapath commands for one word
module rau_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  rau_pkg::sts_t sts_i,
  output rau_pkg::ctl_t ctl_o,
  output logic          busy_o,
  output logic          strobe_o
);
  import rau_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b00000001,
    ST_LOAD = 8'b00000010,
    ST_G1   = 8'b00000100,
    ST_FACT = 8'b00001000,
    ST_MUL  = 8'b00010000,
    ST_G2   = 8'b00100000,
    ST_RED  = 8'b01000000,
    ST_INT  = 8'b10000000
  } state_e;

  state_e state_q, state_d;
  logic   issued_q, issued_d, strobe_q, strobe_d;

  always_comb begin
    state_d  = state_q;
    issued_d = issued_q;
    strobe_d = 1'b0;
    ctl_o.go  = 1'b0;
    ctl_o.cmd = DC_NONE;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ctl_o.go = 1'b1; ctl_o.cmd = DC_LOAD; state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (sts_i.done) begin
          issued_d = 1'b0;
          if (sts_i.err || sts_i.unused_op) begin
            strobe_d = 1'b1; state_d = ST_IDLE;
          end else if (sts_i.int_op) begin
            state_d = ST_INT;
          end else if (sts_i.fadd) begin
            state_d = ST_G1;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      default: begin
        ctl_o.cmd = (state_q == ST_G1)   ? DC_G1 :
                    (state_q == ST_FACT) ? DC_FACT :
                    (state_q == ST_MUL)  ? DC_SUM :
                    (state_q == ST_G2)   ? DC_G2 :
                    (state_q == ST_RED)  ? DC_RED : DC_INT;
        ctl_o.go = !issued_q;
        issued_d = 1'b1;
        if (issued_q && sts_i.done) begin
          issued_d = 1'b0;
          case (state_q)
            ST_G1:   state_d = ST_FACT;
            ST_FACT: state_d = ST_MUL;
            ST_MUL:  state_d = ST_G2;
            ST_G2:   state_d = ST_RED;
            default: begin
              strobe_d = 1'b1; state_d = ST_IDLE;
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      issued_q <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      strobe_q <= strobe_d;
    end
  end

  assign busy_o   = (state_q != ST_IDLE) || strobe_q;
  assign strobe_o = strobe_q;
endmodule

>>> rtl/rational_arithmetic_unit.sv
// rational arithmetic unit top level
// error and unused opcodes end at the load step, mod and quotient take one
// division, and fraction ops run euclid remainder steps around the shared
// 64-bit bit-serial divider
// one word at a time; busy is high from acceptance through the result strobe
// asynchronous active-low reset returns the controller to idle with no result
module rational_arithmetic_unit #(
  parameter int unsigned WIDTH = rau_pkg::DefaultWidth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  rau_pkg::req_t req_i,
  output logic          strobe_o,
  output rau_pkg::rsp_t rsp_o
);
  import rau_pkg::*;

  ctl_t ctl;
  sts_t sts;

  rau_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start && !busy),
    .sts_i   (sts),
    .ctl_o   (ctl),
    .busy_o  (busy),
    .strobe_o(strobe_o)
  );

  rau_datapath #(.Width(WIDTH)) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_i),
    .ctl_i (ctl),
    .sts_o (sts),
    .rsp_o (rsp_o)
  );
endmodule

>>> rtl/rau_checker.sv
// port-level checker for the rational arithmetic unit
module rau_port_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          strobe_o,
  input rau_pkg::rsp_t rsp_o
);
  import rau_pkg::*;

  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> busy) else $error("strobe without busy");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accept did not raise busy");
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |=> !strobe_o) else $error("double strobe");
  a_err_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && rsp_o.status) |-> (rsp_o.res_num == '0 && rsp_o.res_den == 64'd1))
    else $error("error result not 0/1");
endmodule

bind rational_arithmetic_unit rau_port_checker u_rau_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .strobe_o(strobe_o),
  .rsp_o   (rsp_o)
);
